@@ rtl/tmprof_pkg.sv @@
// ============================================================================
// Trapezoidal motion profile package
// Shared widths, command and register codes, and the sequencer state type.
// ============================================================================
package tmprof_pkg;

   // Field widths fixed by the interface
   localparam int CMD_BITS       = 2;
   localparam int ACCEL_BITS     = 32;
   localparam int SPEED_BITS     = 40;
   localparam int TOL_BITS       = 16;
   localparam int VEL_BITS       = 41;
   localparam int VMAG_BITS      = 40;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 40;

   // Arrival tolerance resets to one micro-unit, rounded up
   localparam longint unsigned TOL_SCALE = 64'd1000000;

   // Input command codes
   localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_TARGET = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOL   = 2'd2;

   // Tick sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_CMP,
      ST_SQRT,
      ST_VEL,
      ST_POS,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/tmprof_mul.sv @@
// ============================================================================
// Bit-serial multiplier
// Unsigned shift-add multiplier that retires one multiplier bit per cycle,
// least significant bit first, with an adder as wide as the multiplicand.
// ============================================================================
module tmprof_mul #(
   parameter int MCAND_BITS = 32,
   parameter int STEPS      = 56
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [MCAND_BITS-1:0]       mcand,
   input  logic [STEPS-1:0]            mplier,
   output logic [MCAND_BITS+STEPS-1:0] product,
   output logic                        busy
);

   localparam int CNT_BITS = $clog2(STEPS + 1);

   logic [MCAND_BITS+STEPS-1:0] acc_ff, acc_in;
   logic [MCAND_BITS-1:0]       mcand_ff;
   logic [STEPS-1:0]            mplier_ff, mplier_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic                        busy_ff, busy_in;
   logic [MCAND_BITS:0]         partial;

   // One shift-add step: add the multiplicand into the top of the
   // accumulator when the current multiplier bit is set, then shift right.
   always_comb begin
      partial   = {1'b0, acc_ff[MCAND_BITS+STEPS-1 -: MCAND_BITS]} +
                  {1'b0, (mplier_ff[0] ? mcand_ff : '0)};
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      if (start) begin
         acc_in    = '0;
         mplier_in = mplier;
         count_in  = CNT_BITS'(STEPS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = {partial, acc_ff[STEPS-1:1]};
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff - CNT_BITS'(1);
         busy_in   = (count_ff != CNT_BITS'(1));
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      if (start) begin
         mcand_ff <= mcand;
      end
   end

   assign product = acc_ff;
   assign busy    = busy_ff;

endmodule

@@ rtl/tmprof_sqrt.sv @@
// ============================================================================
// Digit-serial square root
// Restoring integer square root that brings in two radicand bits and
// settles one root bit per cycle.
// ============================================================================
module tmprof_sqrt #(
   parameter int ROOT_BITS = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2*ROOT_BITS-1:0]   radicand,
   output logic [ROOT_BITS-1:0]     root,
   output logic                     busy
);

   localparam int CNT_BITS = $clog2(ROOT_BITS + 1);
   localparam int REM_BITS = ROOT_BITS + 2;

   logic [2*ROOT_BITS-1:0] rad_ff, rad_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic [REM_BITS+1:0]    rem_shift;
   logic [REM_BITS+1:0]    trial;
   logic [REM_BITS+1:0]    diff;

   // One root bit per step: shift the next radicand pair into the
   // remainder and subtract the trial value 4*root+1 when it fits.
   always_comb begin
      rem_shift = {rem_ff, rad_ff[2*ROOT_BITS-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      diff      = rem_shift - trial;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      if (start) begin
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         count_in = CNT_BITS'(ROOT_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rad_in   = rad_ff << 2;
         count_in = count_ff - CNT_BITS'(1);
         busy_in  = (count_ff != CNT_BITS'(1));
         if (rem_shift >= trial) begin
            rem_in  = diff[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign busy = busy_ff;

endmodule

@@ rtl/trapezoidal_motion_profile_top.sv @@
// ============================================================================
// Trapezoidal motion profile generator
// One-axis trapezoidal velocity profile with serial arithmetic units.
// ============================================================================
// Usage:
// The request channel (req_valid/req_ready) takes one command transaction:
// a servo tick, a new target, or a position load. Every transaction yields
// exactly one response transaction (rsp_valid/rsp_ready) carrying position,
// velocity and the done flag after that command.
// Non-tick commands and ticks while done go straight to the emit state,
// which loads the response register. A motion tick runs two bit-serial multiplies
// in parallel (max(POSITION_BITS, 40) steps, 56 by default), a compare, an optional
// 40-step square root, then the velocity update, the position update and the
// response load; the sequencer then returns to idle for the next command.
// The serial multipliers and square root dominate the time of a tick. One command is
// in work at a time; req_ready is high whenever the sequencer is idle,
// also while an earlier response waits in the output register.
// A stalled receiver holds the response register; a finished command then
// waits until the register frees before the block goes idle again.
// Reset clears position, target and velocity, sets done, clears the
// acceleration and speed limits and restores the default tolerance.
// Configuration writes through csr_we/csr_index/csr_wdata while idle.
// ============================================================================
module trapezoidal_motion_profile_top #(
   parameter int FRACTION_BITS = 24,
   parameter int POSITION_BITS = 56
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [tmprof_pkg::CMD_BITS-1:0]          req_command,
   input  logic signed [POSITION_BITS-1:0]          req_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [POSITION_BITS-1:0]          rsp_position,
   output logic signed [tmprof_pkg::VEL_BITS-1:0]   rsp_velocity,
   output logic                                     rsp_done_res,
   input  logic                                     csr_we,
   input  logic [tmprof_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tmprof_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   import tmprof_pkg::*;

   localparam int MUL_STEPS = (POSITION_BITS > VMAG_BITS) ? POSITION_BITS : VMAG_BITS;
   localparam int CMP_BITS  = VMAG_BITS + MUL_STEPS;
   localparam int SUM_BITS  = ((POSITION_BITS > VEL_BITS) ? POSITION_BITS : VEL_BITS) + 1;
   localparam int VX_BITS   = VEL_BITS + 2;
   localparam logic [63:0] TOL_RESET_WIDE =
      ((64'd1 << FRACTION_BITS) + (TOL_SCALE - 64'd1)) / TOL_SCALE;
   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_RESET_WIDE[TOL_BITS-1:0];
   localparam logic signed [POSITION_BITS-1:0] POS_MAX_P = {1'b0, {(POSITION_BITS-1){1'b1}}};
   localparam logic signed [POSITION_BITS-1:0] POS_MIN_P = {1'b1, {(POSITION_BITS-1){1'b0}}};

   // Configuration registers
   logic [ACCEL_BITS-1:0] accel_ff;
   logic [SPEED_BITS-1:0] speed_ff;
   logic [TOL_BITS-1:0]   tol_ff;

   // Axis state and per-tick working registers
   state_type                       state_ff, state_in;
   logic signed [POSITION_BITS-1:0] position_ff, position_in;
   logic signed [POSITION_BITS-1:0] target_ff, target_in;
   logic signed [VEL_BITS-1:0]      velocity_ff, velocity_in;
   logic                            done_ff, done_in;
   logic [POSITION_BITS-1:0]        dist_ff, dist_in;
   logic                            fwd_ff, fwd_in;
   logic [VMAG_BITS-1:0]            desired_ff, desired_in;

   // Response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [POSITION_BITS-1:0] rsp_position_ff;
   logic signed [VEL_BITS-1:0]      rsp_velocity_ff;
   logic                            rsp_done_ff;
   logic                            rsp_load;

   // Arithmetic unit connections
   logic                              mul_start;
   logic                              sqrt_start;
   logic [ACCEL_BITS+MUL_STEPS-1:0]   prod_a;
   logic [VMAG_BITS+MUL_STEPS-1:0]    prod_v;
   logic                              mul_a_busy;
   logic                              mul_v_busy;
   logic [VMAG_BITS-1:0]              sqrt_root;
   logic                              sqrt_busy;
   logic [CMP_BITS-1:0]               brake_term;

   // Distance and direction
   logic signed [POSITION_BITS:0]   diff_tp, diff_pt;
   logic                            fwd_c;
   logic [POSITION_BITS-1:0]        dist_c;
   logic signed [VEL_BITS-1:0]      vel_neg;
   logic [VMAG_BITS-1:0]            vmag_c;

   // Velocity update
   logic signed [VX_BITS-1:0]       vel_x, accel_x, mag_x, desired_x;
   logic signed [VX_BITS-1:0]       vel_up, vel_dn, vel_pick, vmax_x;
   logic signed [VEL_BITS-1:0]      vel_next_c;

   // Position update
   logic signed [SUM_BITS-1:0]      pos_x, vsum_x, sum_x, pmax_x, pmin_x;
   logic signed [POSITION_BITS-1:0] pos_next_c;

   // Configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= '0;
         speed_ff <= '0;
         tol_ff   <= TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACCEL: accel_ff <= csr_wdata[ACCEL_BITS-1:0];
            CSR_SPEED: speed_ff <= csr_wdata[SPEED_BITS-1:0];
            CSR_TOL:   tol_ff   <= csr_wdata[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Distance to target, direction and speed magnitude at the start of a tick
   always_comb begin
      diff_tp = {target_ff[POSITION_BITS-1], target_ff} -
                {position_ff[POSITION_BITS-1], position_ff};
      diff_pt = {position_ff[POSITION_BITS-1], position_ff} -
                {target_ff[POSITION_BITS-1], target_ff};
      fwd_c   = !diff_tp[POSITION_BITS] && (diff_tp != '0);
      dist_c  = fwd_c ? diff_tp[POSITION_BITS-1:0] : diff_pt[POSITION_BITS-1:0];
      vel_neg = -velocity_ff;
      vmag_c  = velocity_ff[VEL_BITS-1] ? vel_neg[VMAG_BITS-1:0]
                                        : velocity_ff[VMAG_BITS-1:0];
   end

   // Serial products a*|d| and v*v
   tmprof_mul #(
      .MCAND_BITS(ACCEL_BITS),
      .STEPS     (MUL_STEPS)
   ) u_mul_accel (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (accel_ff),
      .mplier (MUL_STEPS'(dist_c)),
      .product(prod_a),
      .busy   (mul_a_busy)
   );

   tmprof_mul #(
      .MCAND_BITS(VMAG_BITS),
      .STEPS     (MUL_STEPS)
   ) u_mul_speed (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (vmag_c),
      .mplier (MUL_STEPS'(vmag_c)),
      .product(prod_v),
      .busy   (mul_v_busy)
   );

   // The braking term 2*a*|d|; when it does not exceed v*v it is below 2^80
   assign brake_term = CMP_BITS'({prod_a, 1'b0});

   tmprof_sqrt #(
      .ROOT_BITS(VMAG_BITS)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .radicand(brake_term[2*VMAG_BITS-1:0]),
      .root    (sqrt_root),
      .busy    (sqrt_busy)
   );

   // Velocity steps toward the desired value by at most the acceleration, clamped to +-(2^40-1)
   always_comb begin
      vel_x     = {{(VX_BITS-VEL_BITS){velocity_ff[VEL_BITS-1]}}, velocity_ff};
      accel_x   = {{(VX_BITS-ACCEL_BITS){1'b0}}, accel_ff};
      mag_x     = {{(VX_BITS-VMAG_BITS){1'b0}}, desired_ff};
      desired_x = fwd_ff ? mag_x : -mag_x;
      vmax_x    = {{(VX_BITS-VMAG_BITS){1'b0}}, {VMAG_BITS{1'b1}}};
      vel_up    = vel_x + accel_x;
      vel_dn    = vel_x - accel_x;
      if (desired_x > vel_up) begin
         vel_pick = vel_up;
      end else if (desired_x < vel_dn) begin
         vel_pick = vel_dn;
      end else begin
         vel_pick = desired_x;
      end
      if (vel_pick > vmax_x) begin
         vel_pick = vmax_x;
      end else if (vel_pick < -vmax_x) begin
         vel_pick = -vmax_x;
      end
      vel_next_c = vel_pick[VEL_BITS-1:0];
   end

   // Position adds velocity and saturates to the signed position range
   always_comb begin
      pos_x  = {{(SUM_BITS-POSITION_BITS){position_ff[POSITION_BITS-1]}}, position_ff};
      vsum_x = {{(SUM_BITS-VEL_BITS){velocity_ff[VEL_BITS-1]}}, velocity_ff};
      pmax_x = {{(SUM_BITS-POSITION_BITS){1'b0}}, POS_MAX_P};
      pmin_x = {{(SUM_BITS-POSITION_BITS){1'b1}}, POS_MIN_P};
      sum_x  = pos_x + vsum_x;
      if (sum_x > pmax_x) begin
         pos_next_c = POS_MAX_P;
      end else if (sum_x < pmin_x) begin
         pos_next_c = POS_MIN_P;
      end else begin
         pos_next_c = sum_x[POSITION_BITS-1:0];
      end
   end

   // Command sequencer: next state and axis state updates
   always_comb begin
      state_in    = state_ff;
      position_in = position_ff;
      target_in   = target_ff;
      velocity_in = velocity_ff;
      done_in     = done_ff;
      dist_in     = dist_ff;
      fwd_in      = fwd_ff;
      desired_in  = desired_ff;
      mul_start   = 1'b0;
      sqrt_start  = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
               case (req_command)
                  CMD_TICK: begin
                     if (!done_ff) begin
                        state_in = ST_PREP;
                     end
                  end
                  CMD_TARGET: begin
                     target_in = req_value;
                     done_in   = 1'b0;
                  end
                  CMD_LOAD: begin
                     position_in = req_value;
                     target_in   = req_value;
                     velocity_in = '0;
                     done_in     = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            fwd_in    = fwd_c;
            dist_in   = dist_c;
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (!mul_a_busy && !mul_v_busy) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // Within braking distance: follow the square-root curve
            if (brake_term <= prod_v) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end else begin
               desired_in = speed_ff;
               state_in   = ST_VEL;
            end
         end
         ST_SQRT: begin
            if (!sqrt_busy) begin
               desired_in = sqrt_root;
               state_in   = ST_VEL;
            end
         end
         ST_VEL: begin
            velocity_in = vel_next_c;
            state_in    = ST_POS;
         end
         ST_POS: begin
            // Close enough at the start of the tick: snap to target and stop
            if (dist_ff < POSITION_BITS'(tol_ff)) begin
               position_in = target_ff;
               velocity_in = '0;
               done_in     = 1'b1;
            end else begin
               position_in = pos_next_c;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer and axis state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         position_ff <= '0;
         target_ff   <= '0;
         velocity_ff <= '0;
         done_ff     <= 1'b1;
      end else begin
         state_ff    <= state_in;
         position_ff <= position_in;
         target_ff   <= target_in;
         velocity_ff <= velocity_in;
         done_ff     <= done_in;
      end
   end

   // Per-tick working registers
   always_ff @(posedge clock) begin
      dist_ff    <= dist_in;
      fwd_ff     <= fwd_in;
      desired_ff <= desired_in;
   end

   // Response valid: set on load, cleared when the transaction is taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_position_ff <= position_ff;
         rsp_velocity_ff <= velocity_ff;
         rsp_done_ff     <= done_ff;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_velocity = rsp_velocity_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

@@ sim/tmprof_checker.sv @@
// ============================================================================
// Trapezoidal motion profile checker
// Watches the command, response and register ports, keeps its own copy of
// the axis state, predicts every response and compares it field by field.
// ============================================================================
`timescale 1ns / 1ps

module tmprof_checker #(
   parameter int FRACTION_BITS = 24,
   parameter int POSITION_BITS = 56
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [tmprof_pkg::CMD_BITS-1:0]       req_command,
   input  logic signed [POSITION_BITS-1:0]       req_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [POSITION_BITS-1:0]       rsp_position,
   input  logic signed [tmprof_pkg::VEL_BITS-1:0] rsp_velocity,
   input  logic                                  rsp_done_res,
   input  logic                                  csr_we,
   input  logic [tmprof_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tmprof_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                    failures,
   output int                                    in_flight,
   output int                                    checked,
   output int                                    arrivals
);

   import tmprof_pkg::*;

   // Saturation bounds, widened so that no intermediate sum can wrap
   localparam logic signed [127:0] SPEED_CAP = (128'sd1 <<< (VEL_BITS - 1)) - 128'sd1;
   localparam logic signed [127:0] POS_TOP   = (128'sd1 <<< (POSITION_BITS - 1)) - 128'sd1;
   localparam logic signed [127:0] POS_FLOOR = -POS_TOP - 128'sd1;
   localparam logic [TOL_BITS-1:0] TOL_DEFAULT =
      TOL_BITS'(((64'd1 << FRACTION_BITS) + TOL_SCALE - 64'd1) / TOL_SCALE);

   typedef struct packed {
      logic signed [POSITION_BITS-1:0] pos;
      logic signed [VEL_BITS-1:0]      vel;
      logic                            done;
   } axis_report_type;

   // Axis state and limits as the block should hold them
   logic signed [POSITION_BITS-1:0] axis_pos;
   logic signed [POSITION_BITS-1:0] axis_goal;
   logic signed [VEL_BITS-1:0]      axis_vel;
   logic                            axis_done;
   logic [ACCEL_BITS-1:0]           accel_lim;
   logic [SPEED_BITS-1:0]           speed_lim;
   logic [TOL_BITS-1:0]             arrive_tol;

   // Axis states owed to the response port, oldest first
   axis_report_type axis_reports_due[$];

   // One servo update: pick the desired speed, ramp toward it, move, and
   // snap onto the target when the distance at the start was inside tolerance.
   function automatic void advance_axis();
      logic signed [127:0] pos, goal, vel, step, aim;
      logic [127:0]        gap, reach, vmag, vsq, root, trial;
      logic                toward;
      if (axis_done) return;
      pos    = axis_pos;
      goal   = axis_goal;
      vel    = axis_vel;
      step   = $signed({96'd0, accel_lim});
      toward = goal > pos;
      gap    = toward ? goal - pos : pos - goal;
      reach  = (gap * {96'd0, accel_lim}) << 1;
      vmag   = (vel < 0) ? -vel : vel;
      vsq    = vmag * vmag;

      // Braking region uses the floor square root, otherwise cruise speed
      if (reach <= vsq) begin
         root = '0;
         for (int b = 49; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= reach) root = trial;
         end
         aim = (root > SPEED_CAP) ? SPEED_CAP : $signed(root);
      end else begin
         aim = ({88'd0, speed_lim} > SPEED_CAP) ? SPEED_CAP : $signed({88'd0, speed_lim});
      end
      if (!toward) aim = -aim;

      // Velocity moves by at most one acceleration step
      if (aim > vel + step) vel = vel + step;
      else if (aim < vel - step) vel = vel - step;
      else vel = aim;
      if (vel > SPEED_CAP) vel = SPEED_CAP;
      if (vel < -SPEED_CAP) vel = -SPEED_CAP;

      pos = pos + vel;
      if (pos > POS_TOP) pos = POS_TOP;
      if (pos < POS_FLOOR) pos = POS_FLOOR;
      axis_pos = pos[POSITION_BITS-1:0];
      axis_vel = vel[VEL_BITS-1:0];

      if (gap < {112'd0, arrive_tol}) begin
         axis_pos  = axis_goal;
         axis_vel  = '0;
         axis_done = 1'b1;
         arrivals++;
      end
   endfunction

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, what);
   endfunction

   // Sample every port at the rising edge; responses are matched before a
   // transaction accepted on the same edge is added.
   always @(posedge clock) begin
      axis_report_type due;
      if (reset) begin
         axis_pos   = '0;
         axis_goal  = '0;
         axis_vel   = '0;
         axis_done  = 1'b1;
         accel_lim  = '0;
         speed_lim  = '0;
         arrive_tol = TOL_DEFAULT;
         axis_reports_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACCEL: accel_lim  = csr_wdata[ACCEL_BITS-1:0];
               CSR_SPEED: speed_lim  = csr_wdata[SPEED_BITS-1:0];
               CSR_TOL:   arrive_tol = csr_wdata[TOL_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (axis_reports_due.size() == 0) begin
               note_failure($sformatf("response with nothing outstanding: pos %0d vel %0d",
                                      rsp_position, rsp_velocity));
            end else begin
               due = axis_reports_due.pop_front();
               checked++;
               if (rsp_position !== due.pos || rsp_velocity !== due.vel ||
                   rsp_done_res !== due.done) begin
                  note_failure($sformatf(
                     "response %0d (expected/actual): pos %0d/%0d vel %0d/%0d done %0b/%0b",
                     checked, due.pos, rsp_position, due.vel, rsp_velocity,
                     due.done, rsp_done_res));
               end
            end
         end

         if (req_valid && req_ready) begin
            case (req_command)
               CMD_TICK: advance_axis();
               CMD_TARGET: begin
                  axis_goal = req_value;
                  axis_done = 1'b0;
               end
               CMD_LOAD: begin
                  axis_pos  = req_value;
                  axis_goal = req_value;
                  axis_vel  = '0;
                  axis_done = 1'b1;
               end
               default: ;
            endcase
            due.pos  = axis_pos;
            due.vel  = axis_vel;
            due.done = axis_done;
            axis_reports_due.push_back(due);
         end
      end
      in_flight = axis_reports_due.size();
   end

endmodule

@@ sim/tb.sv @@
// ============================================================================
// Trapezoidal motion profile testbench
// Drives command transactions through several limit settings and idling
// patterns, including one long response hold-off; the checker predicts and
// compares every response, and this module gives the verdict.
// ============================================================================
`timescale 1ns / 1ps

module tb;
   import tmprof_pkg::*;

   localparam int FRAC_BITS   = 24;
   localparam int POS_BITS    = 56;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int TAIL_CYCLES = 120;
   localparam int HOLD_CYCLES = 600;

   // Command code the block does not decode
   localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;

   localparam longint POS_HI = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
   localparam longint POS_LO = -POS_HI - 64'sd1;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [CMD_BITS-1:0]        req_command;
   logic signed [POS_BITS-1:0] req_value;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [POS_BITS-1:0] rsp_position;
   logic signed [VEL_BITS-1:0] rsp_velocity;
   logic                       rsp_done_res;
   logic                       csr_we;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   int     failures;
   int     in_flight;
   int     checked;
   int     arrivals;
   int     cycles         = 0;
   int     items_sent     = 0;
   int     send_idle_pct  = 0;
   int     recv_stall_pct = 0;
   logic   squeeze_req    = 1'b0;
   longint cur_accel      = 0;
   longint cur_tol        = 17;

   trapezoidal_motion_profile_top #(
      .FRACTION_BITS(FRAC_BITS),
      .POSITION_BITS(POS_BITS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_position (rsp_position),
      .rsp_velocity (rsp_velocity),
      .rsp_done_res (rsp_done_res),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   tmprof_checker #(
      .FRACTION_BITS(FRAC_BITS),
      .POSITION_BITS(POS_BITS)
   ) axis_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_position (rsp_position),
      .rsp_velocity (rsp_velocity),
      .rsp_done_res (rsp_done_res),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .failures     (failures),
      .in_flight    (in_flight),
      .checked      (checked),
      .arrivals     (arrivals)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the whole run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles", cycles);
         $display("FAIL trapezoidal_motion_profile_top");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request so the
   // block fills up and has to refuse new commands.
   initial begin
      int hold_left;
      bit squeezed;
      hold_left = 0;
      squeezed  = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_req && !squeezed) begin
            squeezed  = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   function automatic logic signed [POS_BITS-1:0] any_value();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[POS_BITS-1:0];
   endfunction

   // Offer one command transaction and wait for its acceptance
   task automatic offer(input logic [CMD_BITS-1:0] cmd,
                        input logic signed [POS_BITS-1:0] val);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Idle means every response has come back and the sequencer takes input
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (in_flight != 0 || !req_ready) @(negedge clock);
   endtask

   task automatic program_limits(input logic [ACCEL_BITS-1:0] accel,
                                 input logic [SPEED_BITS-1:0] vmax,
                                 input logic [TOL_BITS-1:0]   tol);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_ACCEL;
      csr_wdata <= CSR_DATA_BITS'(accel);
      @(negedge clock);
      csr_index <= CSR_SPEED;
      csr_wdata <= CSR_DATA_BITS'(vmax);
      @(negedge clock);
      csr_index <= CSR_TOL;
      csr_wdata <= CSR_DATA_BITS'(tol);
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_accel = longint'(accel);
      cur_tol   = longint'(tol);
   endtask

   // Random moves: optional load, a target sized to the acceleration so the
   // ramp finishes in about n ticks for a random n up to max_n, then ticks with rare retargets.
   // A share of the commands is plain noise with any code and value.
   task automatic run_moves(input int count, input int max_n);
      int     stop_at, n, ticks;
      longint start, span, goal;
      stop_at = items_sent + count;
      start   = 0;
      while (items_sent < stop_at) begin
         if ($urandom_range(99, 0) < 12) begin
            offer(CMD_BITS'($urandom_range(3, 0)), any_value());
            continue;
         end
         n    = $urandom_range(max_n, 2);
         span = cur_accel * n * n / 4 + longint'($urandom_range(4095, 0));
         if ($urandom_range(99, 0) < 8) span = longint'($urandom_range(cur_tol, 0));
         if ($urandom_range(99, 0) < 60) begin
            case ($urandom_range(9, 0))
               0:       start = POS_HI - longint'($urandom_range(1 << 20, 0));
               1:       start = POS_LO + longint'($urandom_range(1 << 20, 0));
               default: start = $signed({$urandom, $urandom}) >>> 13;
            endcase
            offer(CMD_LOAD, POS_BITS'(start));
         end
         goal = $urandom_range(1, 0) ? start + span : start - span;
         if (goal > POS_HI) goal = POS_HI;
         if (goal < POS_LO) goal = POS_LO;
         offer(CMD_TARGET, POS_BITS'(goal));
         ticks = n + $urandom_range(12, 0);
         for (int k = 0; k < ticks && items_sent < stop_at; k++) begin
            if ($urandom_range(99, 0) < 4) begin
               goal = goal + longint'($urandom_range(8191, 0)) - 4096;
               if (goal > POS_HI) goal = POS_HI;
               if (goal < POS_LO) goal = POS_LO;
               offer(CMD_TARGET, POS_BITS'(goal));
            end else begin
               offer(CMD_TICK, any_value());
            end
         end
         start = goal;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_TICK;
      req_value   = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_ACCEL;
      csr_wdata   = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Reset limits: nothing can move, only the done and snap paths act
      offer(CMD_TICK, '0);
      offer(CMD_SPARE, '1);
      offer(CMD_TARGET, POS_BITS'(5));
      offer(CMD_TICK, '0);
      offer(CMD_TARGET, POS_BITS'(1000));
      offer(CMD_TICK, '1);
      offer(CMD_LOAD, POS_BITS'(POS_HI));
      offer(CMD_TARGET, POS_BITS'(POS_LO));
      offer(CMD_TICK, '0);

      // Full-scale limits and no tolerance: saturation and zero distance
      program_limits('1, '1, '0);
      offer(CMD_TICK, '0);
      offer(CMD_TICK, '0);
      offer(CMD_LOAD, POS_BITS'(POS_HI - 10));
      offer(CMD_TARGET, POS_BITS'(POS_HI));
      offer(CMD_TICK, '0);
      offer(CMD_TICK, '0);
      offer(CMD_LOAD, POS_BITS'(POS_LO + 10));
      offer(CMD_TARGET, POS_BITS'(POS_LO));
      offer(CMD_TICK, '0);
      offer(CMD_SPARE, '0);
      offer(CMD_LOAD, '0);
      offer(CMD_TARGET, '0);
      offer(CMD_TICK, '0);

      // Widest tolerance snaps a sizeable move on its first tick
      program_limits('1, '1, '1);
      offer(CMD_TARGET, POS_BITS'(40000));
      offer(CMD_TICK, '0);

      // Moderate limits, no idling, with the long response hold-off
      program_limits(ACCEL_BITS'(1000), SPEED_BITS'(20000), TOL_BITS'(3000));
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      squeeze_req <= 1'b1;
      run_moves(330, 30);

      // Random limits scaled to converge, sender idling
      begin
         int a;
         a = $urandom_range(16000, 1);
         program_limits(ACCEL_BITS'(a), SPEED_BITS'(a * $urandom_range(40, 2)),
                        TOL_BITS'((a * 3 > 65535) ? 65535 : a * 3));
      end
      send_idle_pct = 72;
      recv_stall_pct <= 0;
      run_moves(330, 30);

      // Full-scale limits, receiver stalling; one run long enough to reach
      // the velocity ceiling
      program_limits('1, '1, '0);
      send_idle_pct = 0;
      recv_stall_pct <= 72;
      offer(CMD_LOAD, POS_BITS'(POS_LO));
      offer(CMD_TARGET, POS_BITS'(POS_HI));
      repeat (280) offer(CMD_TICK, '0);
      run_moves(300, 30);

      // Small acceleration, unlimited speed, widest tolerance, both idling
      program_limits(ACCEL_BITS'($urandom_range(4095, 1)), '1, '1);
      send_idle_pct = 22;
      recv_stall_pct <= 22;
      run_moves(330, 40);

      // Zero acceleration: velocity is frozen
      program_limits('0, SPEED_BITS'({$urandom, $urandom}), TOL_BITS'($urandom));
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      run_moves(60, 10);

      // Random wide limits, both idling
      program_limits(ACCEL_BITS'($urandom_range(1 << 20, 1)),
                     SPEED_BITS'({$urandom, $urandom}), TOL_BITS'($urandom));
      send_idle_pct = 22;
      recv_stall_pct <= 22;
      run_moves(330, 30);

      // Drain, then wait out a tail of TAIL_CYCLES for anything stray
      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d commands under eight limit settings, idling from none to 72%%,",
               items_sent);
      $display("with one %0d-cycle response hold-off; %0d responses checked, %0d arrivals.",
               HOLD_CYCLES, checked, arrivals);
      if (in_flight != 0) $display("%0d expected responses never arrived", in_flight);
      if (failures == 0 && in_flight == 0) begin
         $display("PASS trapezoidal_motion_profile_top");
      end else begin
         $display("FAIL trapezoidal_motion_profile_top");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/tmprof_pkg.sv
rtl/tmprof_mul.sv
rtl/tmprof_sqrt.sv
rtl/trapezoidal_motion_profile_top.sv
sim/tmprof_checker.sv
sim/tb.sv
